@@ sv/kps_pkg.sv @@
package kps_pkg;

  localparam int unsigned TimerWidth = 12;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned CodeWidth  = 7;

  localparam logic [1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] CFG_HOLD_EQUALS = 2'd1;
  localparam logic [1:0] CFG_HOLD_CLEAR  = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd3;

  localparam logic [TimerWidth-1:0] DEBOUNCE_RESET    = 12'd100;
  localparam logic [TimerWidth-1:0] HOLD_EQUALS_RESET = 12'd400;
  localparam logic [TimerWidth-1:0] HOLD_CLEAR_RESET  = 12'd300;
  localparam logic [CountWidth-1:0] THRESHOLD_RESET   = 4'd10;

  localparam logic [3:0] KEY_EQUALS = 4'd13;
  localparam logic [3:0] KEY_CLEAR  = 4'd15;

  localparam logic [CodeWidth-1:0] CODE_NONE  = 7'h6E;
  localparam logic [CodeWidth-1:0] CODE_RESET = 7'h52;
  localparam logic [CodeWidth-1:0] CODE_NEW   = 7'h4E;

  typedef struct packed {
    logic [TimerWidth-1:0] debounce_ticks;
    logic [TimerWidth-1:0] hold_unit_equals;
    logic [TimerWidth-1:0] hold_unit_clear;
    logic [CountWidth-1:0] long_threshold;
  } kps_cfg_t;

  typedef struct packed {
    logic [3:0]           row_drive;
    logic                 key_valid;
    logic [CodeWidth-1:0] key_code;
    logic                 beep;
  } kps_result_t;

  function automatic logic [CodeWidth-1:0] key_ascii(input logic [3:0] key);
    logic [CodeWidth-1:0] code;
    unique case (key)
      4'd0:    code = 7'h2F;
      4'd1:    code = 7'h39;
      4'd2:    code = 7'h38;
      4'd3:    code = 7'h37;
      4'd4:    code = 7'h78;
      4'd5:    code = 7'h36;
      4'd6:    code = 7'h35;
      4'd7:    code = 7'h34;
      4'd8:    code = 7'h2D;
      4'd9:    code = 7'h33;
      4'd10:   code = 7'h32;
      4'd11:   code = 7'h31;
      4'd12:   code = 7'h2B;
      4'd13:   code = 7'h3D;
      4'd14:   code = 7'h30;
      default: code = 7'h63;
    endcase
    return code;
  endfunction

endpackage

@@ sv/kps_if.sv @@
interface kps_cols_if;
  logic       valid;
  logic       ready;
  logic [3:0] columns;

  modport source (output valid, output columns, input ready);
  modport sink (input valid, input columns, output ready);
endinterface

interface kps_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_drive;
  logic       key_valid;
  logic [6:0] key_code;
  logic       beep;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output beep, input ready);
  modport sink (input valid, input row_drive, input key_valid, input key_code,
                input beep, output ready);
endinterface

@@ sv/kps_ctrl.sv @@
module kps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [3:0]           columns,
  input  kps_pkg::kps_cfg_t    cfg,
  output kps_pkg::kps_result_t result
);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_RELEASE  = 2'd2;
  localparam logic [1:0] PH_HOLDWAIT = 2'd3;

  logic [1:0]                      scan_row, scan_row_next;
  logic [1:0]                      phase, phase_next;
  logic [3:0]                      held_key, held_key_next;
  logic [kps_pkg::TimerWidth-1:0]  delay_timer, delay_timer_next;
  logic [kps_pkg::CountWidth-1:0]  hold_count, hold_count_next;

  logic [1:0]                      hit_col;
  logic                            is_eq, is_clr, is_long;
  logic [kps_pkg::TimerWidth-1:0]  unit, timer_dec;

  always_comb begin
    if (!columns[0]) begin
      hit_col = 2'd0;
    end else if (scan_row == 2'd3) begin
      hit_col = !columns[2] ? 2'd2 : (!columns[1] ? 2'd1 : 2'd3);
    end else begin
      hit_col = !columns[1] ? 2'd1 : (!columns[2] ? 2'd2 : 2'd3);
    end
  end

  assign is_eq     = (held_key == kps_pkg::KEY_EQUALS);
  assign is_clr    = (held_key == kps_pkg::KEY_CLEAR);
  assign is_long   = (hold_count >= cfg.long_threshold);
  assign unit      = is_eq ? cfg.hold_unit_equals : cfg.hold_unit_clear;
  assign timer_dec = (delay_timer != '0) ? delay_timer - 1'b1 : delay_timer;

  always_comb begin
    scan_row_next    = scan_row;
    phase_next       = phase;
    held_key_next    = held_key;
    delay_timer_next = delay_timer;
    hold_count_next  = hold_count;
    result.row_drive = ~(4'b0001 << scan_row);
    result.key_valid = 1'b0;
    result.key_code  = kps_pkg::CODE_NONE;
    result.beep      = 1'b0;
    unique case (phase) inside
      PH_IDLE: begin
        if (columns != 4'hF) begin
          held_key_next    = {scan_row, hit_col};
          result.beep      = 1'b1;
          hold_count_next  = '0;
          delay_timer_next = cfg.debounce_ticks;
          phase_next       = (cfg.debounce_ticks != '0) ? PH_DEBOUNCE : PH_RELEASE;
        end else begin
          scan_row_next = scan_row + 2'd1;
        end
      end
      PH_DEBOUNCE, PH_HOLDWAIT: begin
        delay_timer_next = timer_dec;
        if (timer_dec == '0) begin
          phase_next = PH_RELEASE;
        end
      end
      default: begin
        if (!columns[held_key[1:0]]) begin
          if (is_eq || is_clr) begin
            if (hold_count < cfg.long_threshold) begin
              hold_count_next = hold_count + 1'b1;
            end
            if (unit > 12'd1) begin
              delay_timer_next = unit - 1'b1;
              phase_next       = PH_HOLDWAIT;
            end
          end
        end else begin
          result.key_valid = 1'b1;
          if (is_eq && is_long) begin
            result.key_code = kps_pkg::CODE_RESET;
          end else if (is_clr && is_long) begin
            result.key_code = kps_pkg::CODE_NEW;
          end else begin
            result.key_code = kps_pkg::key_ascii(held_key);
          end
          hold_count_next  = '0;
          delay_timer_next = '0;
          scan_row_next    = '0;
          phase_next       = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row    <= '0;
      phase       <= PH_IDLE;
      held_key    <= '0;
      delay_timer <= '0;
      hold_count  <= '0;
    end else if (step) begin
      scan_row    <= scan_row_next;
      phase       <= phase_next;
      held_key    <= held_key_next;
      delay_timer <= delay_timer_next;
      hold_count  <= hold_count_next;
    end
  end

endmodule

@@ sv/keypad_scanner_long_press.sv @@
// A result is registered and presented in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle; a new tick enters in the cycle the previous result
// is taken, so a waiting result stalls the input.
// Reset (rst, synchronous, active high): scanning from row one, idle, timers and
// hold count cleared, registers at their default values, no result pending.
module keypad_scanner_long_press (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  kps_cols_if.sink            cols_ch,
  kps_result_if.source        result_ch
);

  kps_pkg::kps_cfg_t    cfg;
  kps_pkg::kps_result_t step_result;
  kps_pkg::kps_result_t result;
  logic                 result_valid;
  logic                 step;

  assign cols_ch.ready = !result_valid || result_ch.ready;
  assign step          = cols_ch.valid && cols_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= kps_pkg::DEBOUNCE_RESET;
      cfg.hold_unit_equals <= kps_pkg::HOLD_EQUALS_RESET;
      cfg.hold_unit_clear  <= kps_pkg::HOLD_CLEAR_RESET;
      cfg.long_threshold   <= kps_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kps_pkg::CFG_DEBOUNCE:    cfg.debounce_ticks   <= cfg_data;
        kps_pkg::CFG_HOLD_EQUALS: cfg.hold_unit_equals <= cfg_data;
        kps_pkg::CFG_HOLD_CLEAR:  cfg.hold_unit_clear  <= cfg_data;
        default:                  cfg.long_threshold   <= cfg_data[3:0];
      endcase
    end
  end

  kps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .columns (cols_ch.columns),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= step_result;
    end
  end

  assign result_ch.valid     = result_valid;
  assign result_ch.row_drive = result.row_drive;
  assign result_ch.key_valid = result.key_valid;
  assign result_ch.key_code  = result.key_code;
  assign result_ch.beep      = result.beep;

endmodule
